// ----- rtl/awcp_pkg.sv -----
package awcp_pkg;

    localparam int DAYS      = 7;
    localparam int MOMENTS   = 3;
    localparam int KW_COUNT  = DAYS + MOMENTS;
    localparam int WINDOW    = 9;
    localparam int LEN_W     = 6;

    localparam logic [LEN_W-1:0] LINE_LIMIT = 6'd49;

    localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
    localparam logic [4:0] HOURS_PER_DAY    = 5'd24;
    localparam logic [2:0] LAST_DAY         = 3'(DAYS - 1);

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // Result kinds.
    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_FIRED = 2'd2;

    typedef logic [7:0] t_byte;
    typedef logic [WINDOW-1:0][7:0] t_kw;
    typedef logic [WINDOW-2:0][7:0] t_hist;

    // Keywords are right-justified, so the last letter sits in byte 0, the
    // same place as the newest character of the match window.
    localparam t_kw KW_TEXT [KW_COUNT] = '{
        t_kw'("Luni"), t_kw'("Marti"), t_kw'("Miercuri"), t_kw'("Joi"),
        t_kw'("Vineri"), t_kw'("Sambata"), t_kw'("Duminica"),
        t_kw'("Dimineata"), t_kw'("Pranz"), t_kw'("Seara")
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd5, 4'd8, 4'd3, 4'd6, 4'd7, 4'd8, 4'd9, 4'd5, 4'd5
    };

    // One command handed from the line parser to the alarm engine.
    typedef struct packed {
        logic       is_tick;
        logic       ok;
        logic [2:0] day;
        logic [1:0] moment;
        t_byte      hour;
        t_byte      minute;
    } t_cmd;

    function automatic logic kw_hit(input t_kw w, input int k);
        logic hit;
        hit = 1'b1;
        for (int j = 0; j < WINDOW; j++) begin
            if (4'(j) < KW_LEN[k] && w[j] != KW_TEXT[k][j]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic t_byte digit_val(input t_byte c);
        return (c == 8'h00) ? 8'h00 : t_byte'(c - CHAR_ZERO);
    endfunction

    function automatic t_byte times_ten(input t_byte v);
        return t_byte'({v[4:0], 3'b000} + {v[6:0], 1'b0});
    endfunction

endpackage

// ----- rtl/awcp_if.sv -----
interface awcp_in_if import awcp_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  mode;
    t_byte rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface awcp_out_if import awcp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [2:0] alarm_day;
    logic [1:0] alarm_moment;
    t_byte      alarm_hour;
    t_byte      alarm_minute;
    logic [6:0] day_leds;

    modport source (output valid, output kind, output alarm_day, output alarm_moment,
                    output alarm_hour, output alarm_minute, output day_leds,
                    input ready);
    modport sink   (input valid, input kind, input alarm_day, input alarm_moment,
                    input alarm_hour, input alarm_minute, input day_leds,
                    output ready);
endinterface

// ----- rtl/awcp_front.sv -----
module awcp_front import awcp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    awcp_in_if.sink i_in,
    input  logic   i_q_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    logic [LEN_W-1:0]   r_len, n_len;
    t_hist              r_win, n_win;
    logic               r_zero, n_zero;
    logic [DAYS-1:0]    r_day_hits, n_day_hits;
    logic [MOMENTS-1:0] r_mom_hits, n_mom_hits;
    logic [1:0]         r_phase, n_phase;
    t_byte              r_hour, n_hour;
    t_byte              r_minute, n_minute;

    logic  w_acc;
    logic  w_eol;
    t_byte w_c;
    t_kw   w_win;
    logic [2:0] w_first_day;
    logic [1:0] w_first_mom;

    assign i_in.ready = !i_q_full;
    assign w_acc      = i_in.valid && !i_q_full;
    assign w_c        = i_in.rx_byte;
    assign w_eol      = !i_in.mode && (w_c == CHAR_LF || w_c == CHAR_CR);
    assign w_win      = {r_win, w_c};

    always_comb begin
        w_first_day = 3'd0;
        for (int k = DAYS - 1; k >= 0; k--) begin
            if (r_day_hits[k]) begin
                w_first_day = 3'(k);
            end
        end
        w_first_mom = 2'd0;
        for (int k = MOMENTS - 1; k >= 0; k--) begin
            if (r_mom_hits[k]) begin
                w_first_mom = 2'(k);
            end
        end
    end

    assign o_push         = w_acc && (i_in.mode || w_eol);
    assign o_cmd.is_tick  = i_in.mode;
    assign o_cmd.ok       = (|r_day_hits) && (|r_mom_hits);
    assign o_cmd.day      = w_first_day;
    assign o_cmd.moment   = w_first_mom;
    assign o_cmd.hour     = r_hour;
    assign o_cmd.minute   = r_minute;

    always_comb begin
        n_len      = r_len;
        n_win      = r_win;
        n_zero     = r_zero;
        n_day_hits = r_day_hits;
        n_mom_hits = r_mom_hits;
        n_phase    = r_phase;
        n_hour     = r_hour;
        n_minute   = r_minute;
        if (w_acc && !i_in.mode) begin
            if (w_eol) begin
                n_len      = '0;
                n_win      = '0;
                n_zero     = 1'b0;
                n_day_hits = '0;
                n_mom_hits = '0;
                n_phase    = 2'd0;
                n_hour     = '0;
                n_minute   = '0;
            end else if (r_len < LINE_LIMIT) begin
                n_len = r_len + 1'b1;
                if (!r_zero) begin
                    if (w_c == 8'h00) begin
                        n_zero = 1'b1;
                    end else begin
                        priority if (r_phase == 2'd0 && w_c == CHAR_COLON) begin
                            n_hour   = t_byte'(times_ten(digit_val(r_win[1]))
                                       + digit_val(r_win[0]));
                            n_minute = '0;
                            n_phase  = 2'd1;
                        end else if (r_phase == 2'd1) begin
                            n_minute = times_ten(digit_val(w_c));
                            n_phase  = 2'd2;
                        end else if (r_phase == 2'd2) begin
                            n_minute = t_byte'(r_minute + digit_val(w_c));
                            n_phase  = 2'd3;
                        end else begin
                        end
                        n_win = w_win[WINDOW-2:0];
                        for (int k = 0; k < DAYS; k++) begin
                            if (kw_hit(w_win, k)) begin
                                n_day_hits[k] = 1'b1;
                            end
                        end
                        for (int k = 0; k < MOMENTS; k++) begin
                            if (kw_hit(w_win, DAYS + k)) begin
                                n_mom_hits[k] = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_win      <= '0;
            r_zero     <= 1'b0;
            r_day_hits <= '0;
            r_mom_hits <= '0;
            r_phase    <= 2'd0;
            r_hour     <= '0;
            r_minute   <= '0;
        end else begin
            r_len      <= n_len;
            r_win      <= n_win;
            r_zero     <= n_zero;
            r_day_hits <= n_day_hits;
            r_mom_hits <= n_mom_hits;
            r_phase    <= n_phase;
            r_hour     <= n_hour;
            r_minute   <= n_minute;
        end
    end

endmodule

// ----- rtl/awcp_cmd_fifo.sv -----
module awcp_cmd_fifo import awcp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop && r_count == 2'd1) |=> o_full)
        else $error("command queue count lost a beat");
`endif

endmodule

// ----- rtl/awcp_back.sv -----
module awcp_back import awcp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    awcp_out_if.source o_out
);

    logic [5:0]      r_min;
    logic [4:0]      r_hour;
    logic [2:0]      r_day;
    logic [DAYS-1:0] r_act;
    logic [1:0]      r_tab_mom  [DAYS];
    t_byte           r_tab_hour [DAYS];
    t_byte           r_tab_min  [DAYS];
    logic [6:0]      r_leds;

    logic       r_o_valid;
    logic [1:0] r_kind;
    logic [2:0] r_o_day;
    logic [1:0] r_o_mom;
    t_byte      r_o_hour;
    t_byte      r_o_min;
    logic [6:0] r_o_leds;

    logic [5:0] w_nmin;
    logic [4:0] w_nhour;
    logic [2:0] w_nday;
    logic       w_hit;
    logic [6:0] w_set_leds;

    assign o_pop = i_q_valid && (!r_o_valid || o_out.ready);

    always_comb begin
        w_nmin  = r_min + 1'b1;
        w_nhour = r_hour;
        w_nday  = r_day;
        if (w_nmin >= MINUTES_PER_HOUR) begin
            w_nmin  = '0;
            w_nhour = r_hour + 1'b1;
            if (w_nhour >= HOURS_PER_DAY) begin
                w_nhour = '0;
                w_nday  = (r_day == LAST_DAY) ? 3'd0 : r_day + 1'b1;
            end
        end
    end

    // The alarm entry is compared against the clock after it has advanced.
    assign w_hit = r_act[w_nday]
                && r_tab_hour[w_nday] == {3'b000, w_nhour}
                && r_tab_min[w_nday] == {2'b00, w_nmin};

    assign w_set_leds = 7'(1) << i_cmd.day;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= '0;
            r_hour    <= '0;
            r_day     <= '0;
            r_act     <= '0;
            r_leds    <= '0;
            r_o_valid <= 1'b0;
        end else if (o_pop) begin
            if (i_cmd.is_tick) begin
                r_min     <= w_nmin;
                r_hour    <= w_nhour;
                r_day     <= w_nday;
                r_o_valid <= w_hit;
                if (w_hit) begin
                    r_act[w_nday] <= 1'b0;
                end
            end else begin
                r_o_valid <= 1'b1;
                if (i_cmd.ok) begin
                    r_act[i_cmd.day] <= 1'b1;
                    r_leds           <= w_set_leds;
                end
            end
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_cmd.is_tick) begin
                r_kind   <= KIND_FIRED;
                r_o_day  <= w_nday;
                r_o_mom  <= r_tab_mom[w_nday];
                r_o_hour <= r_tab_hour[w_nday];
                r_o_min  <= r_tab_min[w_nday];
                r_o_leds <= r_leds;
            end else if (i_cmd.ok) begin
                r_tab_mom[i_cmd.day]  <= i_cmd.moment;
                r_tab_hour[i_cmd.day] <= i_cmd.hour;
                r_tab_min[i_cmd.day]  <= i_cmd.minute;
                r_kind   <= KIND_SET;
                r_o_day  <= i_cmd.day;
                r_o_mom  <= i_cmd.moment;
                r_o_hour <= i_cmd.hour;
                r_o_min  <= i_cmd.minute;
                r_o_leds <= w_set_leds;
            end else begin
                r_kind   <= KIND_ERROR;
                r_o_day  <= 3'd0;
                r_o_mom  <= 2'd0;
                r_o_hour <= i_cmd.hour;
                r_o_min  <= i_cmd.minute;
                r_o_leds <= r_leds;
            end
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.kind         = r_kind;
    assign o_out.alarm_day    = r_o_day;
    assign o_out.alarm_moment = r_o_mom;
    assign o_out.alarm_hour   = r_o_hour;
    assign o_out.alarm_minute = r_o_min;
    assign o_out.day_leds     = r_o_leds;

`ifndef SYNTHESIS
    a_minute_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.is_tick && r_min == 6'd59) |=> (r_min == 6'd0))
        else $error("minute counter did not wrap at the hour");
    a_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.is_tick && w_hit) |=> !r_act[$past(w_nday)])
        else $error("fired alarm is still active");
    a_set_leds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_cmd.is_tick && i_cmd.ok) |=> ($onehot(r_leds) && r_act[$past(i_cmd.day)]))
        else $error("alarm set left the day LEDs or entry wrong");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_out.ready) |-> !o_pop)
        else $error("stalled result overwritten");
`endif

endmodule

// ----- rtl/weekly_alarm_command_parser_top.sv -----
// Weekly alarm command parser. Each input beat is either a received byte or a
// one-minute tick, and the block takes one beat per clock cycle while the
// command queue is not full. The line parser on the input side matches the
// day and moment keywords, captures the time around the first colon and
// forwards a command at each tick and at each CR or LF; a two-entry command
// queue decouples it from the alarm engine, which keeps the clock and the
// seven-entry alarm table and writes at most one result per command into an
// output register. A result passes the queue and the output register; input
// keeps flowing while a result waits until the queue holds two commands.
module weekly_alarm_command_parser_top import awcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    awcp_in_if.sink     i_in,
    awcp_out_if.source  o_out
);

    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_pop;

    awcp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    awcp_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    awcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_cmd     (w_q_cmd),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule
